### hdl/rarmt_pkg.sv
package rarmt_pkg;

  // Tree geometry
  localparam int unsigned MaxLeaves = 4096;
  localparam int unsigned LeafW     = $clog2(MaxLeaves);
  localparam int unsigned AddrW     = LeafW + 1;
  localparam int unsigned PtrW      = LeafW + 2;
  localparam int unsigned NodeCnt   = 2 * MaxLeaves;
  localparam int unsigned LvlW      = $clog2(LeafW + 1);
  localparam int unsigned CfgW      = 13;
  localparam int unsigned DataW     = 32;

  // Function codes
  localparam logic FuncAdd   = 1'b0;
  localparam logic FuncQuery = 1'b1;

  typedef struct packed {
    logic                    func;
    logic [11:0]             range_lo;
    logic [12:0]             range_hi;
    logic signed [DataW-1:0] addend;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] range_max;
    logic                    empty_range;
  } out_item_t;

  // Memory access slots of one tree level
  typedef enum logic [2:0] {
    SLOT_TAKE_L,
    SLOT_TAKE_R,
    SLOT_KID_L0,
    SLOT_KID_L1,
    SLOT_KID_R0,
    SLOT_KID_R1,
    SLOT_ANC_L,
    SLOT_ANC_R
  } slot_e;

  typedef struct packed {
    logic  clr_start;
    logic  clr_wr;
    logic  cfg_wr;
    logic  load;
    logic  rd;
    logic  use_data;
    slot_e slot;
    logic  climb;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic empty;
    logic is_query;
    logic take_l;
    logic take_r;
    logic top;
    logic has_l;
    logic has_r;
    logic out_busy;
  } stat_t;

  function automatic logic signed [DataW-1:0] smax(input logic signed [DataW-1:0] a,
                                                   input logic signed [DataW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // log2 of the leaf count rounded up to a power of two, saturated
  function automatic logic [LvlW-1:0] tree_log2(input logic [CfgW-1:0] lc);
    logic [CfgW-1:0] m;
    logic [LvlW-1:0] k;
    m = lc - CfgW'(1);
    k = '0;
    for (int i = 0; i < CfgW; i++) begin
      if (m[i]) k = LvlW'(i + 1);
    end
    if (lc <= CfgW'(1)) begin
      k = '0;
    end else if (k > LvlW'(LeafW)) begin
      k = LvlW'(LeafW);
    end
    return k;
  endfunction

endpackage

### hdl/rarmt_ctrl.sv
module rarmt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  rarmt_pkg::stat_t stat_i,
  output rarmt_pkg::cmd_t  cmd_o
);
  import rarmt_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_LEVEL,
    S_ISSUE,
    S_USE,
    S_CLIMB,
    S_CONT,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  slot_e  slot_q, slot_d;
  logic   cfg_fire;

  // Handshakes
  assign cfg_ready_o = (state_q == S_IDLE) || (state_q == S_CLEAR);
  assign in_ready_o  = (state_q == S_IDLE) && !cfg_valid_i;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    slot_d  = slot_q;
    cmd_o   = '0;
    cmd_o.slot = slot_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load = 1'b1;
          state_d    = S_START;
        end
      end
      S_START: begin
        if (stat_i.empty) begin
          state_d = stat_i.is_query ? S_DONE : S_IDLE;
        end else begin
          state_d = S_LEVEL;
        end
      end
      S_LEVEL: begin
        if (stat_i.take_l) begin
          slot_d  = SLOT_TAKE_L;
          state_d = S_ISSUE;
        end else if (stat_i.take_r) begin
          slot_d  = SLOT_TAKE_R;
          state_d = S_ISSUE;
        end else if (stat_i.top) begin
          state_d = S_DONE;
        end else begin
          state_d = S_CLIMB;
        end
      end
      S_ISSUE: begin
        cmd_o.rd = 1'b1;
        state_d  = S_USE;
      end
      S_USE: begin
        cmd_o.use_data = 1'b1;
        case (slot_q)
          SLOT_TAKE_L: begin
            if (stat_i.take_r) begin
              slot_d  = SLOT_TAKE_R;
              state_d = S_ISSUE;
            end else begin
              state_d = stat_i.top ? S_DONE : S_CLIMB;
            end
          end
          SLOT_TAKE_R: state_d = stat_i.top ? S_DONE : S_CLIMB;
          SLOT_KID_L0: begin
            slot_d  = SLOT_KID_L1;
            state_d = S_ISSUE;
          end
          SLOT_KID_R0: begin
            slot_d  = SLOT_KID_R1;
            state_d = S_ISSUE;
          end
          SLOT_KID_L1, SLOT_ANC_L: begin
            if (stat_i.has_r) begin
              slot_d  = stat_i.is_query ? SLOT_ANC_R : SLOT_KID_R0;
              state_d = S_ISSUE;
            end else begin
              state_d = S_LEVEL;
            end
          end
          default: state_d = S_LEVEL;
        endcase
      end
      S_CLIMB: begin
        cmd_o.climb = 1'b1;
        state_d     = S_CONT;
      end
      S_CONT: begin
        if (stat_i.has_l) begin
          slot_d  = stat_i.is_query ? SLOT_ANC_L : SLOT_KID_L0;
          state_d = S_ISSUE;
        end else if (stat_i.has_r) begin
          slot_d  = stat_i.is_query ? SLOT_ANC_R : SLOT_KID_R0;
          state_d = S_ISSUE;
        end else begin
          state_d = S_LEVEL;
        end
      end
      S_DONE: begin
        if (!stat_i.is_query) begin
          state_d = S_IDLE;
        end else if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    // a leaf count write restarts the clearing sweep
    if (cfg_fire) begin
      cmd_o.cfg_wr    = 1'b1;
      cmd_o.clr_start = 1'b1;
      state_d         = S_CLEAR;
    end
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      slot_q  <= SLOT_TAKE_L;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_one_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.rd, cmd_o.use_data, cmd_o.climb, cmd_o.out_load}))
    else $error("more than one datapath action in a cycle");
  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_fire |=> !in_ready_o)
    else $error("item accepted while node stores are being cleared");
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !stat_i.out_busy)
    else $error("result loaded over an untaken result");
`endif

endmodule

### hdl/rarmt_dpath.sv
module rarmt_dpath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rarmt_pkg::in_item_t  in_item_i,
  input  logic [12:0]          cfg_data_i,
  input  rarmt_pkg::cmd_t      cmd_i,
  output rarmt_pkg::stat_t     stat_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rarmt_pkg::out_item_t out_item_o
);
  import rarmt_pkg::*;

  // Node stores: heap order, node i has children 2i and 2i+1, root at 1
  logic signed [DataW-1:0] sm_mem [NodeCnt];
  logic signed [DataW-1:0] pa_mem [NodeCnt];

  logic [LvlW-1:0]  size_k_q, k_q;
  logic [AddrW-1:0] clr_cnt_q;
  logic [PtrW-1:0]  l_q, r_q;
  logic             hl_q, hr_q, empty_q, func_q, out_valid_q;
  logic signed [DataW-1:0] vl_q, vr_q, kid_q, addend_q, rsm_q, rpa_q;
  out_item_t        out_item_q;

  logic [AddrW-1:0] size_n, hi_clip, rd_addr, wr_addr;
  logic [PtrW-1:0]  cl, lu, ru;
  logic             active, merge_c, is_query, sm_we, pa_we;
  logic signed [DataW-1:0] eff, comb_v, sm_wdata, pa_wdata;

  assign is_query = (func_q == FuncQuery);
  assign size_n   = AddrW'(1) << size_k_q;
  assign hi_clip  = (in_item_i.range_hi > size_n) ? size_n : in_item_i.range_hi;
  assign cl       = l_q - PtrW'(1);
  assign active   = l_q < r_q;
  assign eff      = rsm_q + rpa_q;
  assign lu       = (l_q + PtrW'(1)) >> 1;
  assign ru       = r_q >> 1;
  assign merge_c  = (lu - PtrW'(1)) == ru;
  assign comb_v   = (hl_q && hr_q) ? smax(vl_q, vr_q) : (hl_q ? vl_q : vr_q);

  // Read address per slot
  always_comb begin
    case (cmd_i.slot)
      SLOT_TAKE_L: rd_addr = l_q[AddrW-1:0];
      SLOT_TAKE_R: rd_addr = AddrW'(r_q - PtrW'(1));
      SLOT_KID_L0: rd_addr = {cl[AddrW-2:0], 1'b0};
      SLOT_KID_L1: rd_addr = {cl[AddrW-2:0], 1'b1};
      SLOT_KID_R0: rd_addr = {r_q[AddrW-2:0], 1'b0};
      SLOT_KID_R1: rd_addr = {r_q[AddrW-2:0], 1'b1};
      SLOT_ANC_L:  rd_addr = cl[AddrW-1:0];
      SLOT_ANC_R:  rd_addr = r_q[AddrW-1:0];
      default:     rd_addr = '0;
    endcase
  end

  // Write port: clearing, pending add on covered nodes, parent max refresh
  always_comb begin
    sm_we    = 1'b0;
    pa_we    = 1'b0;
    wr_addr  = rd_addr;
    sm_wdata = smax(kid_q, eff);
    pa_wdata = rpa_q + addend_q;
    if (cmd_i.clr_wr) begin
      sm_we    = 1'b1;
      pa_we    = 1'b1;
      wr_addr  = clr_cnt_q;
      sm_wdata = '0;
      pa_wdata = '0;
    end else if (cmd_i.use_data && !is_query) begin
      case (cmd_i.slot)
        SLOT_TAKE_L, SLOT_TAKE_R: pa_we = 1'b1;
        SLOT_KID_L1: begin
          sm_we   = 1'b1;
          wr_addr = cl[AddrW-1:0];
        end
        SLOT_KID_R1: begin
          sm_we   = 1'b1;
          wr_addr = r_q[AddrW-1:0];
        end
        default: ;
      endcase
    end
  end

  // Node stores
  always_ff @(posedge clk_i) begin
    if (sm_we) sm_mem[wr_addr] <= sm_wdata;
    if (pa_we) pa_mem[wr_addr] <= pa_wdata;
    if (cmd_i.rd) begin
      rsm_q <= sm_mem[rd_addr];
      rpa_q <= pa_mem[rd_addr];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_k_q    <= LvlW'(LeafW);
      clr_cnt_q   <= '0;
      k_q         <= '0;
      hl_q        <= 1'b0;
      hr_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cfg_wr) size_k_q <= tree_log2(cfg_data_i);
      if (cmd_i.clr_start) begin
        clr_cnt_q <= '0;
      end else if (cmd_i.clr_wr) begin
        clr_cnt_q <= clr_cnt_q + AddrW'(1);
      end
      if (cmd_i.load) begin
        k_q  <= '0;
        hl_q <= 1'b0;
        hr_q <= 1'b0;
      end else if (cmd_i.use_data && cmd_i.slot == SLOT_TAKE_L) begin
        hl_q <= 1'b1;
      end else if (cmd_i.use_data && cmd_i.slot == SLOT_TAKE_R) begin
        hr_q <= 1'b1;
      end else if (cmd_i.climb) begin
        k_q <= k_q + LvlW'(1);
        // both boundary paths meet: one side carries on
        if (merge_c) begin
          hl_q <= hl_q | hr_q;
          hr_q <= 1'b0;
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Walk pointers and partial maxima
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      l_q      <= PtrW'(size_n) + PtrW'(in_item_i.range_lo);
      r_q      <= PtrW'(size_n) + PtrW'(hi_clip);
      empty_q  <= AddrW'(in_item_i.range_lo) >= hi_clip;
      func_q   <= in_item_i.func;
      addend_q <= in_item_i.addend;
    end else if (cmd_i.climb) begin
      l_q <= lu;
      r_q <= ru;
      if (merge_c) vl_q <= comb_v;
    end else if (cmd_i.use_data) begin
      case (cmd_i.slot)
        SLOT_TAKE_L: vl_q <= hl_q ? smax(vl_q, eff) : eff;
        SLOT_TAKE_R: vr_q <= hr_q ? smax(vr_q, eff) : eff;
        SLOT_KID_L0, SLOT_KID_R0: kid_q <= eff;
        SLOT_ANC_L: vl_q <= vl_q + rpa_q;
        SLOT_ANC_R: vr_q <= vr_q + rpa_q;
        default: ;
      endcase
    end
    if (cmd_i.out_load) begin
      out_item_q.range_max   <= (hl_q || hr_q) ? comb_v : '0;
      out_item_q.empty_range <= !(hl_q || hr_q);
    end
  end

  // Status
  always_comb begin
    stat_o          = '0;
    stat_o.clr_last = &clr_cnt_q;
    stat_o.empty    = empty_q;
    stat_o.is_query = is_query;
    stat_o.take_l   = active && l_q[0];
    stat_o.take_r   = active && r_q[0];
    stat_o.top      = (k_q == size_k_q);
    stat_o.has_l    = hl_q;
    stat_o.has_r    = hr_q;
    stat_o.out_busy = out_valid_q && !out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef NO_ASSERTIONS
  a_merge_drops_right: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.climb && merge_c) |=> !hr_q)
    else $error("right path still active after paths met");
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd |-> (k_q <= size_k_q))
    else $error("walk climbed above the root");
`endif

endmodule

### hdl/range_add_range_max_tree.sv
// Segment tree, range add and range maximum, over up to 4096 signed 32-bit cells.
// An item walks the tree level by level over log2(leaf count) levels; one item at a
// time, as the sequencer takes a new item only while idle and no leaf_count write
// is pending.
// Reset and every leaf_count write start a sweep that zeroes the node
// stores; no item is taken during it. leaf_count resets to 4096.
module range_add_range_max_tree (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rarmt_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rarmt_pkg::out_item_t out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [12:0]          cfg_data_i
);
  import rarmt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer
  rarmt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Node stores, walk pointers and result register
  rarmt_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
